/* design/consensus_log_term_table_assert.svh */
// Assertion macros used by the checker file.
`ifndef CONSENSUS_LOG_TERM_TABLE_ASSERT_SVH
`define CONSENSUS_LOG_TERM_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while dis is high.
`define CLTT_ASSERT_NOW(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("cltt assertion failed");

// Next-cycle implication, disabled while dis is high.
`define CLTT_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("cltt assertion failed");

`endif

/* design/cltt_pkg.sv */
`timescale 1ns / 1ps

package cltt_pkg;

    localparam int IDX_W      = 64;
    localparam int TERM_W     = 64;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;

    localparam int S_TDATA_W  = 128;
    localparam int S_TUSER_W  = 3;
    localparam int M_FIELDS_W = 196;
    localparam int M_TDATA_W  = 200;

    localparam logic REG_BASE_INDEX = 1'b0;

    typedef enum logic [1:0] {
        KIND_APPEND  = 2'd0,
        KIND_STORE   = 2'd1,
        KIND_VOTE    = 2'd2,
        KIND_CONSIST = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        STATUS_OK      = 3'd0,
        STATUS_BELOW   = 3'd1,
        STATUS_GAP     = 3'd2,
        STATUS_FULL    = 3'd3,
        STATUS_DROPPED = 3'd4
    } status_t;

    typedef struct packed {
        logic [TERM_W-1:0] last_term;
        logic [IDX_W-1:0]  last_index;
        logic [IDX_W-1:0]  assigned_index;
        status_t           status;
        logic              ok;
    } result_t;

endpackage

/* design/consensus_log_term_table.sv */
// Result path: input register, then result register.
// Throughput: one request per cycle when not stalled; the term memory is read on
// acceptance, written when the request completes, a one-entry forward between the two.
// Reset: synchronous, active low; the log is empty, base_index is 1, no clearing pass.
`timescale 1ns / 1ps

module consensus_log_term_table #(
    parameter int LOG_DEPTH = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cltt_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cltt_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cltt_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // entry_index [63:0], entry_term [127:64]
    input  logic [cltt_pkg::S_TDATA_W-1:0]  s_tdata,
    // kind [1:0], batch_first [2]
    input  logic [cltt_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // ok [0], status [3:1], assigned_index [67:4], last_index [131:68],
    // last_term [195:132], zero [199:196]
    output logic [cltt_pkg::M_TDATA_W-1:0]  m_tdata
);
    import cltt_pkg::*;

    localparam int AW = $clog2(LOG_DEPTH);
    localparam int CW = $clog2(LOG_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(LOG_DEPTH);

    // configuration
    logic             cfg_wr;
    logic             cfg_index;
    logic [IDX_W-1:0] base_reg;

    assign pready    = 1'b1;
    assign cfg_wr    = psel & penable & pwrite & pready;
    assign cfg_index = paddr[APB_ADDR_W-1];
    assign prdata    = (cfg_index == REG_BASE_INDEX) ? base_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= IDX_W'(1);
        end else if (cfg_wr && cfg_index == REG_BASE_INDEX) begin
            base_reg <= pwdata;
        end
    end

    // input stage
    logic              s_fire;
    logic              ex_fire;
    logic [IDX_W-1:0]  s_idx;
    logic [TERM_W-1:0] s_term;

    logic              ex_valid_reg;
    kind_t             ex_kind_reg;
    logic              ex_first_reg;
    logic [IDX_W-1:0]  ex_idx_reg;
    logic [TERM_W-1:0] ex_term_reg;
    logic              ex_below_reg;
    logic [IDX_W-1:0]  ex_off_reg;

    assign s_idx    = s_tdata[IDX_W-1:0];
    assign s_term   = s_tdata[IDX_W +: TERM_W];
    assign s_fire   = s_tvalid && s_tready;
    assign ex_fire  = ex_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !ex_valid_reg || ex_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg <= 1'b0;
        end else if (s_tready) begin
            ex_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            ex_kind_reg  <= kind_t'(s_tuser[1:0]);
            ex_first_reg <= s_tuser[2];
            ex_idx_reg   <= s_idx;
            ex_term_reg  <= s_term;
            ex_below_reg <= s_idx < base_reg;
            ex_off_reg   <= s_idx - base_reg;
        end
    end

    // term memory
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [TERM_W-1:0] wr_data;
    logic [TERM_W-1:0] mem_term;
    logic [AW-1:0]     rd_addr;

    assign rd_addr = AW'(s_idx - base_reg);

    cltt_term_mem #(
        .DEPTH (LOG_DEPTH),
        .AW    (AW)
    ) u_term_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (s_fire),
        .rd_addr (rd_addr),
        .rd_term (mem_term)
    );

    // log state
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              dropped_reg;
    logic              dropped_next;
    logic [TERM_W-1:0] last_term_reg;
    logic [TERM_W-1:0] last_term_next;

    logic [IDX_W-1:0]  count_ext;
    logic              in_log;
    logic              at_end;
    logic              full;
    logic              dropped_eff;
    logic [IDX_W-1:0]  end_index;
    logic [IDX_W-1:0]  last_index_cur;
    result_t           res_next;
    result_t           res_reg;
    logic              out_valid_reg;

    // last term before the step, used by the vote rule; after the step for the result
    logic [TERM_W-1:0] last_term_cur;
    assign last_term_cur = (count_reg == '0) ? '0 : last_term_reg;

    assign count_ext      = IDX_W'(count_reg);
    assign in_log         = !ex_below_reg && ex_off_reg < count_ext;
    assign at_end         = !ex_below_reg && ex_off_reg == count_ext;
    assign full           = count_reg == FULL_COUNT;
    assign dropped_eff    = ex_first_reg ? 1'b0 : dropped_reg;
    assign end_index      = base_reg + count_ext;
    assign last_index_cur = end_index - IDX_W'(1);

    always_comb begin
        wr_en                   = 1'b0;
        wr_addr                 = AW'(count_reg);
        wr_data                 = ex_term_reg;
        count_next              = count_reg;
        dropped_next            = dropped_reg;
        last_term_next          = last_term_reg;
        res_next.ok             = 1'b0;
        res_next.status         = STATUS_OK;
        res_next.assigned_index = '0;
        res_next.last_index     = last_index_cur;
        res_next.last_term      = last_term_cur;

        unique case (ex_kind_reg)
            KIND_APPEND: begin
                if (full) begin
                    res_next.status = STATUS_FULL;
                end else begin
                    wr_en                   = 1'b1;
                    count_next              = count_reg + CW'(1);
                    last_term_next          = ex_term_reg;
                    res_next.ok             = 1'b1;
                    res_next.assigned_index = end_index;
                end
            end
            KIND_STORE: begin
                dropped_next = dropped_eff;
                if (dropped_eff) begin
                    res_next.status = STATUS_DROPPED;
                end else if (ex_below_reg) begin
                    res_next.status = STATUS_BELOW;
                    dropped_next    = 1'b1;
                end else if (!in_log && !at_end) begin
                    res_next.status = STATUS_GAP;
                    dropped_next    = 1'b1;
                end else if (at_end) begin
                    if (full) begin
                        res_next.status = STATUS_FULL;
                        dropped_next    = 1'b1;
                    end else begin
                        wr_en          = 1'b1;
                        count_next     = count_reg + CW'(1);
                        last_term_next = ex_term_reg;
                        res_next.ok    = 1'b1;
                    end
                end else begin
                    // truncate after the slot on a term conflict
                    if (mem_term != ex_term_reg) begin
                        wr_en          = 1'b1;
                        wr_addr        = AW'(ex_off_reg);
                        count_next     = CW'(ex_off_reg) + CW'(1);
                        last_term_next = ex_term_reg;
                    end
                    res_next.ok = 1'b1;
                end
            end
            KIND_VOTE: begin
                if (ex_idx_reg == '0) begin
                    res_next.ok = last_index_cur == '0;
                end else if (last_term_cur != ex_term_reg) begin
                    res_next.ok = last_term_cur < ex_term_reg;
                end else begin
                    res_next.ok = last_index_cur <= ex_idx_reg;
                end
            end
            KIND_CONSIST: begin
                if (ex_idx_reg == '0 && ex_term_reg == '0) begin
                    res_next.ok = 1'b1;
                end else begin
                    res_next.ok = in_log && mem_term == ex_term_reg;
                end
            end
            default: begin
                res_next.ok = 1'b0;
            end
        endcase

        wr_en = wr_en && ex_fire;
    end

    result_t res_out;
    always_comb begin
        res_out            = res_next;
        res_out.last_index = base_reg + IDX_W'(count_next) - IDX_W'(1);
        res_out.last_term  = (count_next == '0) ? '0 : last_term_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end else if (ex_fire) begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ex_fire) begin
            last_term_reg <= last_term_next;
            res_reg       <= res_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ex_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - M_FIELDS_W)'(0), res_reg};

endmodule

/* design/cltt_term_mem.sv */
`timescale 1ns / 1ps

module cltt_term_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [cltt_pkg::TERM_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [cltt_pkg::TERM_W-1:0] rd_term
);
    import cltt_pkg::*;

    logic [TERM_W-1:0] mem [DEPTH];
    logic [TERM_W-1:0] rd_data_reg;
    logic [AW-1:0]     rd_addr_reg;
    logic              fwd_valid_reg;
    logic [AW-1:0]     fwd_addr_reg;
    logic [TERM_W-1:0] fwd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            rd_addr_reg  <= rd_addr;
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
    end

    // capture the write that lands on the same edge as the read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_valid_reg <= wr_en;
        end
    end

    assign rd_term = (fwd_valid_reg && fwd_addr_reg == rd_addr_reg) ? fwd_data_reg
                                                                     : rd_data_reg;

endmodule

/* design/cltt_checker.sv */
`timescale 1ns / 1ps

`include "consensus_log_term_table_assert.svh"

module cltt_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [cltt_pkg::M_TDATA_W-1:0] m_tdata
);
    import cltt_pkg::*;

    logic              res_ok;
    logic [2:0]        res_status;
    logic [IDX_W-1:0]  res_assigned;

    assign res_ok       = m_tdata[0];
    assign res_status   = m_tdata[3:1];
    assign res_assigned = m_tdata[67:4];

    `CLTT_ASSERT_NEXT(a_reset_empty, aclk, 1'b0, !aresetn, !m_tvalid && s_tready)
    `CLTT_ASSERT_NEXT(a_hold_result, aclk, !aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `CLTT_ASSERT_NOW(a_ok_status, aclk, !aresetn, m_tvalid && res_ok, res_status == STATUS_OK)
    `CLTT_ASSERT_NOW(a_assigned_ok, aclk, !aresetn, m_tvalid && res_assigned != '0, res_ok && res_status == STATUS_OK)

endmodule

bind consensus_log_term_table cltt_checker u_cltt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
